### sv/pip_pkg.sv
// Shared types and constants for the point-in-polygon crossing test.
`default_nettype none
package pip_pkg;

  // Defaults for the top-level parameters
  localparam int MaxVerticesDef = 64;
  localparam int CoordBitsDef   = 16;

  // Fixed field widths
  localparam int SlotBits     = 6;
  localparam int VcountBits   = 7;
  localparam int CountOutBits = 7;
  localparam int ApbAddrBits  = 3;
  localparam int ApbDataBits  = 32;

  // Register map, index = paddr / 4
  localparam logic REG_VERTEX_COUNT = 1'b0;

  // Item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TEST = 1'b1;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LOAD0  = 6'b000010,
    ST_EDGE_A = 6'b000100,
    ST_EDGE_B = 6'b001000,
    ST_TAIL   = 6'b010000,
    ST_DONE   = 6'b100000
  } pip_state_e;

  // Read-port request to the vertex store
  typedef struct packed {
    logic re;
    logic [15:0] addr;
  } pip_rd_req_t;

endpackage
`default_nettype wire

### sv/pip_vstore.sv
// Vertex store: x and y memories, one write port, one registered read port.
`default_nettype none
module pip_vstore #(
  parameter int DEPTH = pip_pkg::MaxVerticesDef,
  parameter int AW    = $clog2(pip_pkg::MaxVerticesDef),
  parameter int C     = pip_pkg::CoordBitsDef
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire  [AW-1:0]           waddr_i,
  input  wire  signed [C-1:0]     wx_i,
  input  wire  signed [C-1:0]     wy_i,
  input  wire  pip_pkg::pip_rd_req_t rd_req_i,
  output logic signed [C-1:0]     rx_o,
  output logic signed [C-1:0]     ry_o
);
  import pip_pkg::*;

  logic signed [C-1:0] mem_x [DEPTH];
  logic signed [C-1:0] mem_y [DEPTH];
  logic [AW-1:0]       raddr;

  assign raddr = rd_req_i.addr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_x[waddr_i] <= wx_i;
      mem_y[waddr_i] <= wy_i;
    end
    if (rd_req_i.re) begin
      rx_o <= mem_x[raddr];
      ry_o <= mem_y[raddr];
    end
  end

endmodule
`default_nettype wire

### sv/pip_mul.sv
// Shared signed multiplier with registered product.
`default_nettype none
module pip_mul #(
  parameter int W = pip_pkg::CoordBitsDef + 1
) (
  input  wire                    clk_i,
  input  wire  signed [W-1:0]    a_i,
  input  wire  signed [W-1:0]    b_i,
  output logic signed [2*W-1:0]  p_o
);
  import pip_pkg::*;

  always_ff @(posedge clk_i) begin
    p_o <= (2*W)'(a_i) * (2*W)'(b_i);
  end

endmodule
`default_nettype wire

### sv/point_in_polygon_crossing_test.sv
// Top level of the even-odd point-in-polygon crossing test.
`default_nettype none
// Even-odd point-in-polygon test. A load beat (mode 0) writes one vertex into
// the vertex store at vertex_index without stalling the input; slots at or above
// MAX_VERTICES are dropped. A test beat (mode 1) walks the closed polygon of
// min(vertex_count, MAX_VERTICES) vertices, each edge through EDGE_A then
// EDGE_B, because each edge needs two products (u*dy and ey*d) from the single
// shared multiplier. An edge counts when the point's x lies strictly inside its
// x span and the edge's y at that x is at or above the point's y; the test is
// done by exact cross-multiplication, no divide. A test holds the input
// stalled while it reads vertex 0 to prime the walk, walks the edges, settles
// the last compare and posts the result; a stalled result side holds it longer.
// n = 0 goes straight to DONE and posts count 0 and is_outside 1.
// The result sits in an output register, so the next beat may be accepted
// while it waits. vertex_count is set through the APB port at byte address 0
// and must only be written while no test is in flight. The store is not
// cleared at reset: a test must only touch slots already loaded.
module point_in_polygon_crossing_test #(
  parameter int MAX_VERTICES = pip_pkg::MaxVerticesDef,
  parameter int COORD_BITS   = pip_pkg::CoordBitsDef
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  // input channel
  input  wire                                    in_valid_i,
  output logic                                   in_stall_o,
  input  wire  [0:0]                             mode_i,
  input  wire  [pip_pkg::SlotBits-1:0]           vertex_index_i,
  input  wire  signed [COORD_BITS-1:0]           coord_x_i,
  input  wire  signed [COORD_BITS-1:0]           coord_y_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output logic [0:0]                             is_outside_o,
  output logic [pip_pkg::CountOutBits-1:0]       crossing_count_o,
  // config port
  input  wire                                    psel,
  input  wire                                    penable,
  input  wire                                    pwrite,
  input  wire  [pip_pkg::ApbAddrBits-1:0]        paddr,
  input  wire  [pip_pkg::ApbDataBits-1:0]        pwdata,
  output logic [pip_pkg::ApbDataBits-1:0]        prdata,
  output logic                                   pready
);
  import pip_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int D  = COORD_BITS + 1;          // difference width
  localparam int AW = $clog2(MAX_VERTICES);    // store address
  localparam int CW = $clog2(MAX_VERTICES + 1); // vertex / crossing count

  // ---------------------------------------------------------------- config
  logic [VcountBits-1:0] vcount_q;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
    end else if (cfg_wr && paddr[2] == REG_VERTEX_COUNT) begin
      vcount_q <= pwdata[VcountBits-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_VERTEX_COUNT) begin
      prdata = ApbDataBits'(vcount_q);
    end
  end

  // ------------------------------------------------------------- sequencer
  pip_state_e state_q, state_d;

  logic              in_fire, out_fire, done_fire;
  logic [CW-1:0]     n_d, n_q;        // vertices in this test
  logic [CW-1:0]     idx_q, idx_d;    // current edge
  logic [CW:0]       nxt;             // vertex read for the following edge
  logic              last_q, last_d;  // current edge closes to vertex 0
  logic [CW-1:0]     count_q, count_d;
  logic              pend_q, pend_d;  // a compare is waiting on the product
  logic              span_q, span2_q;

  logic signed [C-1:0] px_q, py_q;
  logic signed [C-1:0] first_x_q, first_y_q;
  logic signed [C-1:0] prev_x_q, prev_y_q;
  logic signed [C-1:0] rx, ry, cur_x, cur_y;

  logic signed [D-1:0] u, d, dy, ey;
  logic signed [D-1:0] d_q, ey_q;
  logic signed [D-1:0] mul_a, mul_b;
  logic signed [2*D-1:0] prod, lhs_q;
  logic                span;

  pip_rd_req_t         rd_req;
  logic                st_we;
  logic [AW-1:0]       st_waddr;
  logic [AW+SlotBits-1:0] slot_ext;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign out_fire   = out_valid_o & ~out_stall_i;
  assign done_fire  = (state_q == ST_DONE) & (~out_valid_o | ~out_stall_i);

  // vertex_count above the store depth saturates
  always_comb begin
    if (32'(vcount_q) > MAX_VERTICES) n_d = CW'(MAX_VERTICES);
    else                              n_d = CW'(vcount_q);
  end

  // load path: slots beyond the store are dropped
  assign slot_ext = (AW + SlotBits)'(vertex_index_i);
  assign st_waddr = slot_ext[AW-1:0];
  assign st_we    = in_fire && (mode_i == MODE_LOAD) &&
                    (32'(vertex_index_i) < MAX_VERTICES);

  // edge endpoints: prev is vertex idx, cur is vertex idx+1 or vertex 0
  assign cur_x = last_q ? first_x_q : rx;
  assign cur_y = last_q ? first_y_q : ry;

  // strict x span, then orient so the x difference d is not negative
  always_comb begin
    span = ((prev_x_q < px_q) && (px_q < cur_x)) ||
           ((prev_x_q > px_q) && (px_q > cur_x));
    u  = D'(px_q) - D'(cur_x);
    d  = D'(prev_x_q) - D'(cur_x);
    dy = D'(prev_y_q) - D'(cur_y);
    ey = D'(py_q) - D'(cur_y);
    if (d < 0) begin
      u = -u;
      d = -d;
    end
  end

  // shared multiplier: u*dy in EDGE_A, ey*d in EDGE_B
  assign mul_a = (state_q == ST_EDGE_A) ? u  : ey_q;
  assign mul_b = (state_q == ST_EDGE_A) ? dy : d_q;

  pip_mul #(.W(D)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign nxt = (CW + 1)'(idx_q) + (CW + 1)'(2);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    last_d      = last_q;
    count_d     = count_q;
    pend_d      = pend_q;
    rd_req.re   = 1'b0;
    rd_req.addr = '0;

    // settle the compare of the previous edge: u*dy >= ey*d
    if ((state_q == ST_EDGE_A || state_q == ST_TAIL) && pend_q) begin
      pend_d = 1'b0;
      if (span2_q && (lhs_q >= prod)) count_d = count_q + CW'(1);
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire && mode_i == MODE_TEST) begin
          idx_d   = '0;
          count_d = '0;
          pend_d  = 1'b0;
          if (n_d == '0) begin
            state_d = ST_DONE;
          end else begin
            rd_req.re = 1'b1;   // vertex 0
            state_d   = ST_LOAD0;
          end
        end
      end
      ST_LOAD0: begin
        last_d = (n_q == CW'(1));
        if (n_q != CW'(1)) begin
          rd_req.re   = 1'b1;   // vertex 1
          rd_req.addr = 16'(1);
        end
        state_d = ST_EDGE_A;
      end
      ST_EDGE_A: begin
        state_d = ST_EDGE_B;
      end
      ST_EDGE_B: begin
        pend_d = 1'b1;
        if (last_q) begin
          state_d = ST_TAIL;
        end else begin
          idx_d  = idx_q + CW'(1);
          last_d = (nxt == (CW + 1)'(n_q));
          if (nxt < (CW + 1)'(n_q)) begin
            rd_req.re   = 1'b1;
            rd_req.addr = 16'(nxt);
          end
          state_d = ST_EDGE_A;
        end
      end
      ST_TAIL: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (done_fire) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  pip_vstore #(.DEPTH(MAX_VERTICES), .AW(AW), .C(C)) u_vstore (
    .clk_i    (clk_i),
    .we_i     (st_we),
    .waddr_i  (st_waddr),
    .wx_i     (coord_x_i),
    .wy_i     (coord_y_i),
    .rd_req_i (rd_req),
    .rx_o     (rx),
    .ry_o     (ry)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      last_q  <= 1'b0;
      count_q <= '0;
      pend_q  <= 1'b0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      if (in_fire && mode_i == MODE_TEST) n_q <= n_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_fire && mode_i == MODE_TEST) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
    end
    if (state_q == ST_LOAD0) begin
      first_x_q <= rx;
      first_y_q <= ry;
      prev_x_q  <= rx;
      prev_y_q  <= ry;
    end
    if (state_q == ST_EDGE_A) begin
      prev_x_q <= cur_x;
      prev_y_q <= cur_y;
      d_q      <= d;
      ey_q     <= ey;
      span_q   <= span;
    end
    if (state_q == ST_EDGE_B) begin
      lhs_q   <= prod;     // u*dy
      span2_q <= span_q;
    end
  end

  // --------------------------------------------------------- result beat
  logic [CW+CountOutBits-1:0] count_ext;
  assign count_ext = (CW + CountOutBits)'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      if (done_fire)     out_valid_o <= 1'b1;
      else if (out_fire) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      is_outside_o     <= ~count_q[0];
      crossing_count_o <= count_ext[CountOutBits-1:0];
    end
  end

  // ------------------------------------------------------------ checks
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result beat raised outside DONE");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= n_q)
    else $error("crossing count exceeds vertex count");

  a_edge_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EDGE_A || state_q == ST_EDGE_B) |-> idx_q < n_q)
    else $error("edge index past vertex count");

  a_last_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EDGE_B && last_q) |-> (32'(idx_q) + 1 == 32'(n_q)))
    else $error("closing edge taken at wrong index");

endmodule
`default_nettype wire
